/* rtl/core/ltc_biphase_interval_decoder_top_defines.svh */
// ----------------------------------------------------------------------------
// LTC biphase decoder assertion macros
// Shared helpers for the concurrent checks of the decoder top level.
// ----------------------------------------------------------------------------
`ifndef LTC_BIPHASE_INTERVAL_DECODER_TOP_DEFINES_SVH
`define LTC_BIPHASE_INTERVAL_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbd check failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define LBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbd check failed: next-cycle implication");

`endif

/* rtl/core/lbd_pkg.sv */
// ----------------------------------------------------------------------------
// LTC biphase decoder package
// Shared widths, constants, event codes and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package lbd_pkg;

  // Field and register widths.
  localparam int unsigned TimeW    = 32;
  localparam int unsigned WinW     = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned FramesW  = 6;
  localparam int unsigned SecondsW = 7;
  localparam int unsigned MinutesW = 7;
  localparam int unsigned HoursW   = 6;

  // Frame geometry.
  localparam int unsigned FrameBits = 80;
  localparam int unsigned CntW      = 7;
  localparam logic [7:0]  SyncLow   = 8'hFC;
  localparam logic [7:0]  SyncHigh  = 8'hBF;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgZeroMin = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgZeroMax = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgOneMin  = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgOneMax  = 8'd3;

  // Window reset values in microseconds.
  localparam logic [WinW-1:0] ZeroMinRst = 16'd700;
  localparam logic [WinW-1:0] ZeroMaxRst = 16'd900;
  localparam logic [WinW-1:0] OneMinRst  = 16'd300;
  localparam logic [WinW-1:0] OneMaxRst  = 16'd500;

  // Result status codes.
  localparam logic [StatusW-1:0] StOk          = 2'd0;
  localparam logic [StatusW-1:0] StBadInterval = 2'd1;
  localparam logic [StatusW-1:0] StBadParity   = 2'd2;
  localparam logic [StatusW-1:0] StBadSync     = 2'd3;

  // Queue depth between the classifier and the frame assembler.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  // Events passed from the classifier to the frame assembler.
  typedef enum logic [1:0] {
    EV_RESTART = 2'd0,
    EV_BIT0    = 2'd1,
    EV_BIT1    = 2'd2,
    EV_ERROR   = 2'd3
  } ev_e;

  typedef struct packed {
    logic valid;
    ev_e  ev;
  } ev_item_t;

  // Two BCD digits to binary: tens * 10 + units, no digit correction.
  function automatic logic [6:0] bcd_to_bin(input logic [2:0] tens, input logic [3:0] units);
    logic [6:0] t7;
    t7 = {4'd0, tens};
    return (t7 << 3) + (t7 << 1) + {3'd0, units};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lbd_front.sv */
// ----------------------------------------------------------------------------
// LTC biphase decoder front end
// Accepts transitions, measures intervals and classes them into bit events.
// ----------------------------------------------------------------------------
`default_nettype none

module lbd_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Transition input channel.
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [lbd_pkg::TimeW-1:0]    transition_time_i,
  input  wire logic                         frame_start_i,
  // Configuration writes.
  input  wire logic                         cfg_valid_i,
  input  wire logic [lbd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [lbd_pkg::WinW-1:0]     cfg_data_i,
  // Event push into the queue.
  input  wire logic                         q_ready_i,
  output lbd_pkg::ev_item_t                 push_o
);

  logic [lbd_pkg::WinW-1:0]  zero_min_q, zero_max_q, one_min_q, one_max_q;
  logic [lbd_pkg::TimeW-1:0] last_time_q, last_time_d;
  logic                      have_ref_q, have_ref_d;
  logic                      half_q, half_d;
  logic [lbd_pkg::TimeW-1:0] delta;
  logic                      zero_win, one_win;
  logic                      accept;
  logic                      has_ev;
  lbd_pkg::ev_e              ev;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & q_ready_i;

  // Interval since the previous transition, modulo 2^32, and window tests.
  assign delta    = transition_time_i - last_time_q;
  assign zero_win = (delta > {16'd0, zero_min_q}) && (delta < {16'd0, zero_max_q});
  assign one_win  = (delta > {16'd0, one_min_q}) && (delta < {16'd0, one_max_q});

  // Classify the transition and update the reference and half-bit state.
  always_comb begin
    last_time_d = last_time_q;
    have_ref_d  = have_ref_q;
    half_d      = half_q;
    has_ev      = 1'b1;
    ev          = lbd_pkg::EV_RESTART;
    if (accept) begin
      last_time_d = transition_time_i;
      if (frame_start_i || !have_ref_q) begin
        have_ref_d = 1'b1;
        half_d     = 1'b0;
        ev         = lbd_pkg::EV_RESTART;
      end else if (half_q) begin
        half_d = 1'b0;
        ev     = one_win ? lbd_pkg::EV_BIT1 : lbd_pkg::EV_ERROR;
      end else if (zero_win) begin
        ev = lbd_pkg::EV_BIT0;
      end else if (one_win) begin
        half_d = 1'b1;
        has_ev = 1'b0;
      end else begin
        ev = lbd_pkg::EV_ERROR;
      end
    end
  end

  assign push_o.valid = accept & has_ev;
  assign push_o.ev    = ev;

  // Classifier state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
      have_ref_q  <= 1'b0;
      half_q      <= 1'b0;
    end else begin
      last_time_q <= last_time_d;
      have_ref_q  <= have_ref_d;
      half_q      <= half_d;
    end
  end

  // Window registers; writes to indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_min_q <= lbd_pkg::ZeroMinRst;
      zero_max_q <= lbd_pkg::ZeroMaxRst;
      one_min_q  <= lbd_pkg::OneMinRst;
      one_max_q  <= lbd_pkg::OneMaxRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lbd_pkg::CfgZeroMin: zero_min_q <= cfg_data_i;
        lbd_pkg::CfgZeroMax: zero_max_q <= cfg_data_i;
        lbd_pkg::CfgOneMin:  one_min_q  <= cfg_data_i;
        lbd_pkg::CfgOneMax:  one_max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lbd_queue.sv */
// ----------------------------------------------------------------------------
// LTC biphase decoder event queue
// Small FIFO of bit events between the classifier and the frame assembler.
// ----------------------------------------------------------------------------
`default_nettype none

module lbd_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lbd_pkg::ev_item_t push_i,
  output logic                   ready_o,
  output lbd_pkg::ev_item_t      head_o,
  input  wire logic              pop_i
);

  lbd_pkg::ev_e                entry_q [lbd_pkg::QDepth];
  logic [lbd_pkg::QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [lbd_pkg::QCntW-1:0]   count_q;
  logic                        do_push, do_pop;

  assign ready_o      = (count_q != lbd_pkg::QCntW'(lbd_pkg::QDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.ev    = entry_q[rd_ptr_q];

  assign do_push = push_i.valid & ready_o;
  assign do_pop  = pop_i & head_o.valid;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.ev;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lbd_back.sv */
// ----------------------------------------------------------------------------
// LTC biphase decoder back end
// Assembles bit events into 80-bit frames, checks them and registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module lbd_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Queue head.
  input  wire lbd_pkg::ev_item_t             head_i,
  output logic                               pop_o,
  // Result channel.
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [lbd_pkg::StatusW-1:0]        status_o,
  output logic [lbd_pkg::FramesW-1:0]        frames_o,
  output logic [lbd_pkg::SecondsW-1:0]       seconds_o,
  output logic [lbd_pkg::MinutesW-1:0]       minutes_o,
  output logic [lbd_pkg::HoursW-1:0]         hours_o
);

  logic [lbd_pkg::FrameBits-1:0] frame_q, frame_d, full;
  logic [lbd_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic                          par_q, par_d, par_fin;
  logic                          out_valid_q, out_valid_d;
  logic [lbd_pkg::StatusW-1:0]   status_q, status_d;
  logic [lbd_pkg::FramesW-1:0]   frames_q, frames_d;
  logic [lbd_pkg::SecondsW-1:0]  seconds_q, seconds_d;
  logic [lbd_pkg::MinutesW-1:0]  minutes_q, minutes_d;
  logic [lbd_pkg::HoursW-1:0]    hours_q, hours_d;
  logic                          bit_val, is_bit, last_bit, needs_out, out_free, load;
  logic                          sync_ok;
  logic [6:0]                    frames_w, hours_w;

  assign bit_val   = (head_i.ev == lbd_pkg::EV_BIT1);
  assign is_bit    = (head_i.ev == lbd_pkg::EV_BIT0) || (head_i.ev == lbd_pkg::EV_BIT1);
  assign last_bit  = is_bit && (cnt_q == lbd_pkg::CntW'(lbd_pkg::FrameBits - 1));
  assign needs_out = (head_i.ev == lbd_pkg::EV_ERROR) || last_bit;
  assign out_free  = !out_valid_q || out_ready_i;
  assign pop_o     = head_i.valid && (!needs_out || out_free);

  // Completed frame as it stands once the final bit is in.
  always_comb begin
    full = frame_q;
    full[lbd_pkg::FrameBits-1] = bit_val;
  end

  assign par_fin  = par_q ^ bit_val;
  assign sync_ok  = (full[71:64] == lbd_pkg::SyncLow) && (full[79:72] == lbd_pkg::SyncHigh);
  assign frames_w = lbd_pkg::bcd_to_bin({1'b0, full[9:8]}, full[3:0]);
  assign hours_w  = lbd_pkg::bcd_to_bin({1'b0, full[57:56]}, full[51:48]);

  // Frame assembly and result selection.
  always_comb begin
    frame_d   = frame_q;
    cnt_d     = cnt_q;
    par_d     = par_q;
    load      = 1'b0;
    status_d  = lbd_pkg::StOk;
    frames_d  = '0;
    seconds_d = '0;
    minutes_d = '0;
    hours_d   = '0;
    if (pop_o) begin
      unique case (head_i.ev)
        lbd_pkg::EV_RESTART: begin
          frame_d = '0;
          cnt_d   = '0;
          par_d   = 1'b0;
        end
        lbd_pkg::EV_ERROR: begin
          frame_d  = '0;
          cnt_d    = '0;
          par_d    = 1'b0;
          load     = 1'b1;
          status_d = lbd_pkg::StBadInterval;
        end
        lbd_pkg::EV_BIT0, lbd_pkg::EV_BIT1: begin
          if (last_bit) begin
            frame_d = '0;
            cnt_d   = '0;
            par_d   = 1'b0;
            load    = 1'b1;
            if (par_fin) begin
              status_d = lbd_pkg::StBadParity;
            end else if (!sync_ok) begin
              status_d = lbd_pkg::StBadSync;
            end else begin
              status_d  = lbd_pkg::StOk;
              frames_d  = frames_w[lbd_pkg::FramesW-1:0];
              seconds_d = lbd_pkg::bcd_to_bin(full[26:24], full[19:16]);
              minutes_d = lbd_pkg::bcd_to_bin(full[42:40], full[35:32]);
              hours_d   = hours_w[lbd_pkg::HoursW-1:0];
            end
          end else begin
            frame_d[cnt_q] = bit_val;
            par_d          = par_q ^ bit_val;
            cnt_d          = cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register holds a result until the receiver takes it.
  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= '0;
      cnt_q       <= '0;
      par_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      frame_q     <= frame_d;
      cnt_q       <= cnt_d;
      par_q       <= par_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q  <= status_d;
      frames_q  <= frames_d;
      seconds_q <= seconds_d;
      minutes_q <= minutes_d;
      hours_q   <= hours_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign frames_o    = frames_q;
  assign seconds_o   = seconds_q;
  assign minutes_o   = minutes_q;
  assign hours_o     = hours_q;

endmodule

`default_nettype wire

/* rtl/core/ltc_biphase_interval_decoder_top.sv */
// ----------------------------------------------------------------------------
// LTC biphase interval decoder
// Decodes linear timecode frames from biphase-mark transition timestamps.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries one transition timestamp in microseconds
// and a frame_start flag. A transfer on the result channel carries a status
// and the decoded frames, seconds, minutes and hours; at most one result
// follows each transition. Window registers 0..3 (zero_min, zero_max,
// one_min, one_max) are written through the configuration channel, which is
// always ready and should be used only while the decoder is idle.
// Throughput is one transition per cycle while in_ready_o is high. The
// classifier pushes the event of a transferred transition into the event
// queue at the transfer edge; the frame assembler pops it from the head and
// loads the result register once that register is free.
// Reset restores the default windows, drops the reference time and clears
// the frame being assembled. While the receiver stalls, the held result
// stays on the output and bit events keep draining; once the next
// result-producing event reaches the head, the two-entry event queue fills
// and in_ready_o falls until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ltc_biphase_interval_decoder_top_defines.svh"

module ltc_biphase_interval_decoder_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Transition channel.
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [lbd_pkg::TimeW-1:0]     transition_time_i,
  input  wire logic                          frame_start_i,
  // Configuration channel.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lbd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [lbd_pkg::WinW-1:0]      cfg_data_i,
  // Result channel.
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [lbd_pkg::StatusW-1:0]        status_o,
  output logic [lbd_pkg::FramesW-1:0]        frames_o,
  output logic [lbd_pkg::SecondsW-1:0]       seconds_o,
  output logic [lbd_pkg::MinutesW-1:0]       minutes_o,
  output logic [lbd_pkg::HoursW-1:0]         hours_o
);

  lbd_pkg::ev_item_t push, head;
  logic              q_ready, pop;

  assign cfg_ready_o = 1'b1;

  // Classifier.
  lbd_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .transition_time_i (transition_time_i),
    .frame_start_i     (frame_start_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .q_ready_i         (q_ready),
    .push_o            (push)
  );

  // Event queue.
  lbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .head_o  (head),
    .pop_i   (pop)
  );

  // Frame assembler and result register.
  lbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .frames_o    (frames_o),
    .seconds_o   (seconds_o),
    .minutes_o   (minutes_o),
    .hours_o     (hours_o)
  );

  // Events are only pushed for transitions that are actually transferred.
  `LBD_ASSERT_IMPL(a_push_on_accept, push.valid, in_valid_i && in_ready_o)
  // An empty queue never holds back the input.
  `LBD_ASSERT_IMPL(a_ready_when_empty, !head.valid, in_ready_o)
  // Failed frames and bad intervals report zero time fields.
  `LBD_ASSERT_IMPL(a_error_fields_zero, out_valid_o && (status_o != lbd_pkg::StOk), (frames_o == '0) && (seconds_o == '0) && (minutes_o == '0) && (hours_o == '0))
  // A frame start transfer always leaves a restart event queued.
  `LBD_ASSERT_NEXT(a_restart_queued, in_valid_i && in_ready_o && frame_start_i, head.valid)

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LTC biphase interval decoder testbench
// Feeds transition timestamps through the decoder under several window
// settings and idle patterns, predicts every result in place and compares
// each result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  // Result of one decoded frame, or of an error.
  typedef struct packed {
    logic [lbd_pkg::StatusW-1:0]  status;
    logic [lbd_pkg::FramesW-1:0]  frames;
    logic [lbd_pkg::SecondsW-1:0] seconds;
    logic [lbd_pkg::MinutesW-1:0] minutes;
    logic [lbd_pkg::HoursW-1:0]   hours;
  } timecode_t;

  // One row of the directed table; value is a timestamp or an interval.
  typedef struct packed {
    logic        absolute;
    logic [31:0] value;
    logic        fs;
    logic        typed;
    timecode_t   want;
  } stim_row_t;

  typedef enum int {
    SEQ_GOOD,
    SEQ_PARITY,
    SEQ_SYNC,
    SEQ_BROKEN
  } seq_kind_e;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned MaxGap       = 60;
  localparam int unsigned NumPhases    = 7;
  localparam int unsigned MinResults   = 48;

  localparam timecode_t NoResult    = '0;
  localparam timecode_t BadInterval = '{lbd_pkg::StBadInterval, 6'd0, 7'd0, 7'd0, 6'd0};

  // Directed part, run with the reset windows 700..900 and 300..500.
  localparam int unsigned NumRows = 23;
  localparam stim_row_t DirectedRows [0:NumRows-1] = '{
    '{1'b1, 32'hFFFF_FF00, 1'b0, 1'b0, NoResult},     // no reference yet
    '{1'b0, 32'd800,       1'b0, 1'b0, NoResult},     // zero bit across the wrap
    '{1'b0, 32'd899,       1'b0, 1'b0, NoResult},     // top of the zero window
    '{1'b0, 32'd701,       1'b0, 1'b0, NoResult},     // bottom of the zero window
    '{1'b0, 32'd900,       1'b0, 1'b1, BadInterval},  // zero bound is exclusive
    '{1'b0, 32'd400,       1'b0, 1'b0, NoResult},     // first short half
    '{1'b0, 32'd499,       1'b0, 1'b0, NoResult},     // second half completes a one
    '{1'b0, 32'd301,       1'b0, 1'b0, NoResult},
    '{1'b0, 32'd800,       1'b0, 1'b1, BadInterval},  // second half is long
    '{1'b0, 32'd700,       1'b0, 1'b1, BadInterval},
    '{1'b0, 32'd300,       1'b0, 1'b1, BadInterval},
    '{1'b0, 32'd500,       1'b0, 1'b1, BadInterval},
    '{1'b0, 32'd0,         1'b0, 1'b1, BadInterval},
    '{1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, BadInterval},
    '{1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, NoResult},     // frame start
    '{1'b1, 32'h0000_031F, 1'b0, 1'b0, NoResult},     // 800 us modulo 2^32
    '{1'b0, 32'd400,       1'b0, 1'b0, NoResult},
    '{1'b1, 32'h0000_0000, 1'b1, 1'b0, NoResult},     // frame start with a half open
    '{1'b0, 32'd400,       1'b0, 1'b0, NoResult},
    '{1'b0, 32'd400,       1'b0, 1'b0, NoResult},
    '{1'b1, 32'hAAAA_AAAA, 1'b1, 1'b0, NoResult},
    '{1'b1, 32'h5555_5555, 1'b0, 1'b1, BadInterval},  // huge interval
    '{1'b0, 32'd1,         1'b0, 1'b1, BadInterval}   // error transition is the reference
  };

  // Window settings and idle patterns of the random phases.
  localparam logic [lbd_pkg::WinW-1:0] PhZeroMin [0:NumPhases-1] =
    '{700, 1700, 0, 10, 65535, 500, 700};
  localparam logic [lbd_pkg::WinW-1:0] PhZeroMax [0:NumPhases-1] =
    '{900, 2100, 65535, 13, 0, 501, 900};
  localparam logic [lbd_pkg::WinW-1:0] PhOneMin  [0:NumPhases-1] =
    '{300, 800, 0, 3, 65535, 200, 300};
  localparam logic [lbd_pkg::WinW-1:0] PhOneMax  [0:NumPhases-1] =
    '{500, 1100, 65535, 6, 0, 202, 500};
  localparam int unsigned     PhSendIdle [0:NumPhases-1] = '{0, 85, 0, 7, 0, 85, 0};
  localparam int unsigned     PhRecvStall[0:NumPhases-1] = '{0, 0, 85, 7, 85, 0, 0};
  localparam int unsigned     PhItems    [0:NumPhases-1] = '{60, 80, 40, 80, 20, 20, 200};

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [lbd_pkg::TimeW-1:0]    transition_time_i = '0;
  logic                         frame_start_i = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [lbd_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [lbd_pkg::WinW-1:0]     cfg_data_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [lbd_pkg::StatusW-1:0]  status_o;
  logic [lbd_pkg::FramesW-1:0]  frames_o;
  logic [lbd_pkg::SecondsW-1:0] seconds_o;
  logic [lbd_pkg::MinutesW-1:0] minutes_o;
  logic [lbd_pkg::HoursW-1:0]   hours_o;

  ltc_biphase_interval_decoder_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .transition_time_i(transition_time_i),
    .frame_start_i    (frame_start_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .frames_o         (frames_o),
    .seconds_o        (seconds_o),
    .minutes_o        (minutes_o),
    .hours_o          (hours_o)
  );

  // Decoder state as predicted by the testbench.
  logic [lbd_pkg::WinW-1:0]  win_zero_lo, win_zero_hi, win_one_lo, win_one_hi;
  logic [31:0]               dec_last_stamp;
  logic                      dec_have_ref;
  logic                      dec_half_open;
  logic [63:0]               dec_bits_lo;
  logic [15:0]               dec_bits_hi;
  logic [lbd_pkg::CntW-1:0]  dec_bit_count;
  logic                      dec_parity;

  timecode_t        expected_frames [$];
  logic [31:0]      line_time;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  logic             hold_active = 1'b0;
  int unsigned      cycle_count = 0;
  int unsigned      mismatch_count = 0;
  int unsigned      items_sent = 0;
  int unsigned      results_checked = 0;
  int unsigned      status_seen [0:3] = '{0, 0, 0, 0};

  // Clock.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Cycle counter with the run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic in_window(input logic [31:0] d, input logic [lbd_pkg::WinW-1:0] lo,
                                     input logic [lbd_pkg::WinW-1:0] hi);
    return (d > {16'd0, lo}) && (d < {16'd0, hi});
  endfunction

  task automatic clear_assembly();
    dec_half_open = 1'b0;
    dec_bits_lo   = '0;
    dec_bits_hi   = '0;
    dec_bit_count = '0;
    dec_parity    = 1'b0;
  endtask

  // Advances the predicted decoder by one transition.
  task automatic decode_transition(input logic [31:0] stamp, input logic fs,
                                   output logic produced, output timecode_t res);
    logic [31:0] delta;
    logic        b;
    int          f, s, m, h;
    produced = 1'b0;
    res      = NoResult;
    if (fs || !dec_have_ref) begin
      clear_assembly();
      dec_last_stamp = stamp;
      dec_have_ref   = 1'b1;
      return;
    end
    delta          = stamp - dec_last_stamp;
    dec_last_stamp = stamp;
    if (dec_half_open) begin
      if (!in_window(delta, win_one_lo, win_one_hi)) begin
        clear_assembly();
        produced   = 1'b1;
        res.status = lbd_pkg::StBadInterval;
        return;
      end
      dec_half_open = 1'b0;
      b = 1'b1;
    end else if (in_window(delta, win_zero_lo, win_zero_hi)) begin
      b = 1'b0;
    end else if (in_window(delta, win_one_lo, win_one_hi)) begin
      dec_half_open = 1'b1;
      return;
    end else begin
      clear_assembly();
      produced   = 1'b1;
      res.status = lbd_pkg::StBadInterval;
      return;
    end
    if (dec_bit_count < 64) dec_bits_lo[dec_bit_count] = b;
    else dec_bits_hi[dec_bit_count - 64] = b;
    dec_parity    = dec_parity ^ b;
    dec_bit_count = dec_bit_count + 1;
    if (dec_bit_count < lbd_pkg::FrameBits) return;
    produced = 1'b1;
    if (dec_parity) begin
      res.status = lbd_pkg::StBadParity;
    end else if (dec_bits_hi[7:0] != lbd_pkg::SyncLow ||
                 dec_bits_hi[15:8] != lbd_pkg::SyncHigh) begin
      res.status = lbd_pkg::StBadSync;
    end else begin
      f = int'(dec_bits_lo[9:8]) * 10 + int'(dec_bits_lo[3:0]);
      s = int'(dec_bits_lo[26:24]) * 10 + int'(dec_bits_lo[19:16]);
      m = int'(dec_bits_lo[42:40]) * 10 + int'(dec_bits_lo[35:32]);
      h = int'(dec_bits_lo[57:56]) * 10 + int'(dec_bits_lo[51:48]);
      res.status  = lbd_pkg::StOk;
      res.frames  = lbd_pkg::FramesW'(f);
      res.seconds = lbd_pkg::SecondsW'(s);
      res.minutes = lbd_pkg::MinutesW'(m);
      res.hours   = lbd_pkg::HoursW'(h);
    end
    clear_assembly();
  endtask

  // Sends one transition, with an optional idle gap before it, and predicts it.
  task automatic send_transition(input logic [31:0] stamp, input logic fs,
                                 input logic typed, input timecode_t want);
    int unsigned gap;
    logic        produced;
    timecode_t   res;
    gap = 0;
    while (gap < MaxGap && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    transition_time_i <= stamp;
    frame_start_i     <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    decode_transition(stamp, fs, produced, res);
    if (typed) begin
      produced = 1'b1;
      res      = want;
    end
    if (produced) begin
      expected_frames.push_back(res);
      status_seen[res.status]++;
    end
  endtask

  task automatic send_interval(input logic [31:0] delta);
    line_time = line_time + delta;
    send_transition(line_time, 1'b0, 1'b0, NoResult);
  endtask

  // An interval inside a window, often right at its edges; any interval if the window is empty.
  function automatic logic [31:0] pick_inside(input logic [lbd_pkg::WinW-1:0] lo,
                                              input logic [lbd_pkg::WinW-1:0] hi);
    int unsigned l, h, r;
    l = lo;
    h = hi;
    if (h < l + 2) return $urandom_range(0, 65535);
    r = $urandom_range(0, 7);
    if (r == 0) return l + 1;
    if (r == 1) return h - 1;
    return $urandom_range(l + 1, h - 1);
  endfunction

  // An interval that falls in neither window, where one can be found.
  function automatic logic [31:0] pick_outside();
    logic [31:0] d;
    d = $urandom_range(0, 70000);
    for (int i = 0; i < 20; i++) begin
      if ($urandom_range(0, 15) == 0) d = $urandom;
      else d = $urandom_range(0, 70000);
      if (!in_window(d, win_zero_lo, win_zero_hi) && !in_window(d, win_one_lo, win_one_hi))
        return d;
    end
    return d;
  endfunction

  // Sends one biphase-mark frame, well formed or with a chosen defect.
  task automatic send_frame(input seq_kind_e kind);
    logic [79:0] bits;
    int unsigned cut;
    bits = {16'($urandom), $urandom, $urandom};
    bits[79:64] = {lbd_pkg::SyncHigh, lbd_pkg::SyncLow};
    if (kind == SEQ_SYNC) bits[64 + $urandom_range(0, 15)] ^= 1'b1;
    // Bit 27 lies outside every decoded field and makes the ones count even.
    if (^bits) bits[27] = ~bits[27];
    if (kind == SEQ_PARITY) bits[$urandom_range(0, 79)] ^= 1'b1;
    cut = (kind == SEQ_BROKEN) ? $urandom_range(0, 79) : lbd_pkg::FrameBits;
    if ($urandom_range(0, 9) < 7) begin
      line_time = line_time + $urandom_range(0, 5000);
      send_transition(line_time, 1'b1, 1'b0, NoResult);
    end
    for (int i = 0; i < lbd_pkg::FrameBits; i++) begin
      if (i == cut) begin
        if (bits[i] && $urandom_range(0, 1) == 1)
          send_interval(pick_inside(win_one_lo, win_one_hi));
        send_interval(pick_outside());
        return;
      end
      if (bits[i]) begin
        send_interval(pick_inside(win_one_lo, win_one_hi));
        send_interval(pick_inside(win_one_lo, win_one_hi));
      end else begin
        send_interval(pick_inside(win_zero_lo, win_zero_hi));
      end
    end
  endtask

  // A short burst of unrelated transitions.
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) begin
        line_time = $urandom;
        send_transition(line_time, ($urandom_range(0, 3) == 0), 1'b0, NoResult);
      end else begin
        send_interval($urandom_range(0, 2000));
      end
    end
  endtask

  // Writes one register through the configuration channel; valid stays high.
  task automatic write_reg(input logic [lbd_pkg::CfgIdxW-1:0] idx,
                           input logic [lbd_pkg::WinW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      lbd_pkg::CfgZeroMin: win_zero_lo = data;
      lbd_pkg::CfgZeroMax: win_zero_hi = data;
      lbd_pkg::CfgOneMin:  win_one_lo  = data;
      lbd_pkg::CfgOneMax:  win_one_hi  = data;
      default: ;
    endcase
  endtask

  task automatic program_windows(input logic [lbd_pkg::WinW-1:0] zlo,
                                 input logic [lbd_pkg::WinW-1:0] zhi,
                                 input logic [lbd_pkg::WinW-1:0] olo,
                                 input logic [lbd_pkg::WinW-1:0] ohi);
    write_reg(lbd_pkg::CfgZeroMin, zlo);
    write_reg(lbd_pkg::CfgZeroMax, zhi);
    write_reg(lbd_pkg::CfgOneMin, olo);
    write_reg(lbd_pkg::CfgOneMax, ohi);
    // An index past the last register must leave the windows alone.
    write_reg(lbd_pkg::CfgIdxW'($urandom_range(lbd_pkg::CfgOneMax + 1, 255)),
              lbd_pkg::WinW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every predicted result has been taken, then lets the pipe settle.
  task automatic wait_idle();
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Result side: check each transfer, then choose next cycle's ready.
  always @(posedge clk_i) begin
    timecode_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (expected_frames.size() == 0) begin
        flag_mismatch($sformatf("unexpected result, status %0d", status_o));
      end else begin
        want = expected_frames.pop_front();
        if (status_o !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
        if (frames_o !== want.frames)
          flag_mismatch($sformatf("frames %0d, want %0d", frames_o, want.frames));
        if (seconds_o !== want.seconds)
          flag_mismatch($sformatf("seconds %0d, want %0d", seconds_o, want.seconds));
        if (minutes_o !== want.minutes)
          flag_mismatch($sformatf("minutes %0d, want %0d", minutes_o, want.minutes));
        if (hours_o !== want.hours)
          flag_mismatch($sformatf("hours %0d, want %0d", hours_o, want.hours));
      end
    end
    out_ready_i <= !hold_active && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Main sequence: reset, directed table, then the random phases.
  initial begin
    int unsigned phase_start;
    int unsigned results_start;
    int unsigned r;
    win_zero_lo    = lbd_pkg::ZeroMinRst;
    win_zero_hi    = lbd_pkg::ZeroMaxRst;
    win_one_lo     = lbd_pkg::OneMinRst;
    win_one_hi     = lbd_pkg::OneMaxRst;
    dec_last_stamp = '0;
    dec_have_ref   = 1'b0;
    line_time      = '0;
    clear_assembly();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table against the reset windows.
    for (int i = 0; i < NumRows; i++) begin
      if (DirectedRows[i].absolute) line_time = DirectedRows[i].value;
      else line_time = line_time + DirectedRows[i].value;
      send_transition(line_time, DirectedRows[i].fs, DirectedRows[i].typed,
                      DirectedRows[i].want);
    end
    in_valid_i <= 1'b0;
    wait_idle();

    // Random phases, one window setting and idle pattern each.
    results_start = expected_frames.size() + results_checked;
    for (int p = 0; p < NumPhases; p++) begin
      program_windows(PhZeroMin[p], PhZeroMax[p], PhOneMin[p], PhOneMax[p]);
      send_idle_pct  = PhSendIdle[p];
      recv_stall_pct = PhRecvStall[p];
      if (p == NumPhases - 1) begin
        // Long receiver hold-off while transitions keep coming.
        fork
          begin
            @(posedge clk_i);
            hold_active <= 1'b1;
            repeat (HoldCycles) @(posedge clk_i);
            hold_active <= 1'b0;
          end
        join_none
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PhItems[p] ||
             (p == NumPhases - 1 &&
              expected_frames.size() + results_checked - results_start < MinResults)) begin
        r = $urandom_range(0, 99);
        if (r < 55) send_frame(SEQ_GOOD);
        else if (r < 65) send_frame(SEQ_PARITY);
        else if (r < 75) send_frame(SEQ_SYNC);
        else if (r < 88) send_frame(SEQ_BROKEN);
        else send_noise();
      end
      in_valid_i <= 1'b0;
      wait_idle();
    end

    $display("covered %0d transitions in %0d phases, %0d results compared",
             items_sent, NumPhases + 1, results_checked);
    $display("results: %0d timecodes, %0d bad intervals, %0d bad parity, %0d bad sync",
             status_seen[lbd_pkg::StOk], status_seen[lbd_pkg::StBadInterval],
             status_seen[lbd_pkg::StBadParity], status_seen[lbd_pkg::StBadSync]);
    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (expected_frames.size() != 0)
        flag_mismatch($sformatf("%0d results never arrived", expected_frames.size()));
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
